FILE: rtl/jhsd_pkg.sv
// Package for the Huffman scan decoder with hidden-message extraction.
// Holds shared constants, register indexes and result types; no dependencies.
package jhsd_pkg;

  localparam int unsigned TableCountDef      = 4;
  localparam int unsigned MaxCodeLengthDef   = 16;
  localparam int unsigned SymbolsPerTableDef = 256;

  localparam int unsigned CodeW = 16;

  // configuration register indexes
  localparam logic [2:0] RegCompCount = 3'd0;
  localparam logic [2:0] RegComp1Tab  = 3'd1;
  localparam logic [2:0] RegComp2Tab  = 3'd2;
  localparam logic [2:0] RegComp3Tab  = 3'd3;
  localparam logic [2:0] RegSkipCount = 3'd4;
  localparam logic [2:0] RegLeastBits = 3'd5;

  // input opcodes
  localparam logic [1:0] OpLoadCount  = 2'd0;
  localparam logic [1:0] OpLoadSymbol = 2'd1;
  localparam logic [1:0] OpScanByte   = 2'd2;
  localparam logic [1:0] OpBeginScan  = 2'd3;

  // decode phases
  localparam logic [1:0] PhDcCode = 2'd0;
  localparam logic [1:0] PhAcCode = 2'd1;
  localparam logic [1:0] PhDcVal  = 2'd2;
  localparam logic [1:0] PhAcVal  = 2'd3;

  // result kinds
  localparam logic [2:0] KindDc      = 3'd0;
  localparam logic [2:0] KindAc      = 3'd1;
  localparam logic [2:0] KindZrl     = 3'd2;
  localparam logic [2:0] KindEob     = 3'd3;
  localparam logic [2:0] KindMsgLen  = 3'd4;
  localparam logic [2:0] KindMsgByte = 3'd5;
  localparam logic [2:0] KindMsgDone = 3'd6;
  localparam logic [2:0] KindEndScan = 3'd7;

  localparam logic [7:0] MarkerByte = 8'hFF;
  localparam logic [7:0] StuffByte  = 8'h00;
  localparam logic [7:0] EoiByte    = 8'hD9;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        comp;
    logic [3:0]        run;
    logic signed [15:0] coef;
    logic [7:0]        mbyte;
    logic [15:0]       mlen;
  } res_t;

endpackage

FILE: rtl/jpeg_huffman_scan_decoder_stego.sv
// Top level of the Huffman scan decoder with hidden-message extraction.
// Depends on jhsd_pkg and jhsd_ram (code count and symbol memories).
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready      | tuser opcode, tdata table/index/data
//  m_axis    | out       | m_axis_tvalid/tready      | tuser kind, tdata fields, tlast
//  cfg       | in        | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Loads and begin-scan items are taken in the idle state. A scan byte walks
// its eight bits one at a time: a code bit passes the bit step and the count
// step (count memory read, compare), plus the symbol step on a match (symbol
// memory read); a value bit passes the bit step only, and each result passes
// the emit step. Results stall the walk only when both the hold stage and the
// output register are full. Reset clears all control state; the tables are
// undefined until loaded. Config writes are taken in every cycle.
module jpeg_huffman_scan_decoder_stego
  import jhsd_pkg::*;
#(
  parameter int unsigned TableCount      = jhsd_pkg::TableCountDef,
  parameter int unsigned MaxCodeLength   = jhsd_pkg::MaxCodeLengthDef,
  parameter int unsigned SymbolsPerTable = jhsd_pkg::SymbolsPerTableDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // table_number[1:0], entry_index[9:2], data_value[17:10]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // component[1:0], zero_run[5:2], coefficient[21:6], message_byte[29:22],
  // message_length[45:30]
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // kind[2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned CntDepth = TableCount * MaxCodeLength;
  localparam int unsigned SymDepth = TableCount * SymbolsPerTable;
  localparam int unsigned CaW      = $clog2(CntDepth);
  localparam int unsigned SaW      = $clog2(SymDepth);
  localparam int unsigned BaseW    = MaxCodeLength + 10;
  localparam int unsigned OffW     = $clog2(MaxCodeLength * 255 + 1) + 1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StBit   = 6'b000010,
    StCnt   = 6'b000100,
    StSym   = 6'b001000,
    StEmit  = 6'b010000,
    StFlush = 6'b100000
  } state_e;

  // configuration
  logic [1:0] cc_q, c1_q, c2_q, c3_q;
  logic [7:0] skip_cnt_q;
  logic [3:0] least_q;

  state_e state_q, state_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  bidx_q, bidx_d;
  logic        mark_q, mark_d, stop_q, stop_d, more_q, more_d;
  logic [15:0] pc_q, pc_d, ext_q, ext_d;
  logic [4:0]  plen_q, plen_d;
  logic [1:0]  ph_q, ph_d, comp_q, comp_d;
  logic [6:0]  pos_q, pos_d;
  logic [7:0]  skip_q, skip_d, acc_q, acc_d;
  logic [19:0] hcnt_q, hcnt_d;
  logic [15:0] hl_q, hl_d;
  logic [3:0]  vsize_q, vsize_d, vrun_q, vrun_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [OffW-1:0]  off_q, off_d;

  // pending results of one event: main, length, byte, done, end block
  logic [4:0]  flg_q, flg_d;
  res_t        ev_q, ev_d;

  res_t pend_q, pend_d, out_q, out_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d, out_last_q, out_last_d;

  // memories
  logic           cnt_we, sym_we;
  logic [CaW-1:0] cnt_waddr, cnt_raddr;
  logic [SaW-1:0] sym_waddr, sym_raddr;
  logic [7:0]     cnt_rdata, sym_rdata;

  // scratch
  logic [1:0]  opc, tsel, tnum;
  logic [1:0]  in_tab;
  logic [7:0]  in_idx, in_val;
  logic        tval, bitv, adv, sgn, qual, mdone, match, out_free;
  logic [15:0] full, val;
  logic [4:0]  plen_n;
  logic [BaseW-1:0] code_x, diff;
  logic [OffW-1:0]  sidx;
  logic [19:0] hcnt_n, hrem;
  logic [6:0]  pos_n;
  logic [2:0]  cnext;
  logic [3:0]  sz;
  res_t        r;

  jhsd_ram #(.Width(8), .Depth(CntDepth)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(in_val),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  jhsd_ram #(.Width(8), .Depth(SymDepth)) u_sym_ram (
    .clk_i, .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(in_val),
    .raddr_i(sym_raddr), .rdata_o(sym_rdata)
  );

  assign opc    = s_axis_tuser;
  assign in_tab = s_axis_tdata[1:0];
  assign in_idx = s_axis_tdata[9:2];
  assign in_val = s_axis_tdata[17:10];

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_v_q || m_axis_tready;

  // table for the current component and phase
  assign tsel = (comp_q == 2'd0) ? c1_q : ((comp_q == 2'd1) ? c2_q : c3_q);
  assign tnum = (ph_q == PhDcCode) ? {1'b0, tsel[1]} : {1'b1, tsel[0]};
  assign tval = 32'(tnum) < TableCount;

  // canonical compare against the base for the current length
  assign code_x = BaseW'(pc_q);
  assign diff   = code_x - base_q;
  assign sidx   = off_q + OffW'(diff);
  assign match  = tval && (code_x >= base_q) && (diff < BaseW'(cnt_rdata)) &&
                  (32'(sidx) < SymbolsPerTable);
  assign sym_raddr = SaW'(32'(tnum) * SymbolsPerTable + 32'(sidx));

  assign bitv = byte_q[bidx_q];
  assign mdone = (hcnt_q >= 20'd16) && (hrem[19:3] >= {1'b0, hl_q});
  assign hrem  = hcnt_q - 20'd16;
  assign cnext = 3'(comp_q) + 3'd1;

  always_comb begin
    state_d = state_q; byte_d = byte_q; bidx_d = bidx_q; mark_d = mark_q;
    stop_d = stop_q; more_d = more_q; pc_d = pc_q; ext_d = ext_q;
    plen_d = plen_q; ph_d = ph_q; comp_d = comp_q; pos_d = pos_q;
    skip_d = skip_q; acc_d = acc_q; hcnt_d = hcnt_q; hl_d = hl_q;
    vsize_d = vsize_q; vrun_d = vrun_q; base_d = base_q; off_d = off_q;
    flg_d = flg_q; ev_d = ev_q; pend_d = pend_q; pend_v_d = pend_v_q;
    out_d = out_q; out_v_d = out_v_q; out_last_d = out_last_q;
    cnt_we = 1'b0; sym_we = 1'b0;
    cnt_waddr = CaW'(32'(in_tab) * MaxCodeLength + 32'(in_idx));
    sym_waddr = SaW'(32'(in_tab) * SymbolsPerTable + 32'(in_idx));
    plen_n = plen_q + 5'd1;
    cnt_raddr = CaW'(32'(tnum) * MaxCodeLength + 32'(plen_n) - 32'd1);
    adv = 1'b0; sgn = 1'b0; qual = 1'b0; full = '0; val = '0;
    hcnt_n = hcnt_q; pos_n = pos_q; sz = '0; r = '0;

    if (m_axis_tready && out_v_q) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          case (opc)
            OpLoadCount: begin
              cnt_we = (32'(in_tab) < TableCount) && (32'(in_idx) < MaxCodeLength);
            end
            OpLoadSymbol: begin
              sym_we = (32'(in_tab) < TableCount) && (32'(in_idx) < SymbolsPerTable);
            end
            OpBeginScan: begin
              mark_d = 1'b0; pc_d = '0; plen_d = '0; ph_d = PhDcCode; ext_d = '0;
              comp_d = '0; pos_d = '0; skip_d = skip_cnt_q; hcnt_d = '0; hl_d = '0;
              acc_d = '0; stop_d = 1'b0; vsize_d = '0; vrun_d = '0;
              base_d = '0; off_d = '0;
            end
            default: begin
              if (!stop_q) begin
                if (mark_q) begin
                  mark_d = 1'b0;
                  if (in_val == StuffByte) begin
                    byte_d = MarkerByte; bidx_d = 3'd7; state_d = StBit;
                  end else if (in_val == EoiByte) begin
                    // end of image: stop and report
                    stop_d = 1'b0 | 1'b1;
                    ev_d = '0; ev_d.kind = KindEndScan; ev_d.comp = comp_q;
                    flg_d = 5'b00001; more_d = 1'b0; state_d = StEmit;
                  end
                end else if (in_val == MarkerByte) begin
                  mark_d = 1'b1;
                end else begin
                  byte_d = in_val; bidx_d = 3'd7; state_d = StBit;
                end
              end
            end
          endcase
        end
      end

      StBit: begin
        if (ph_q >= PhDcVal) begin
          // value bits: collect, then sign-extend and handle
          ext_d = {ext_q[14:0], bitv};
          plen_d = plen_n;
          if (plen_n >= {1'b0, vsize_q}) begin
            plen_d = '0;
            full = 16'((17'd1 << vsize_q) - 17'd1);
            sgn = ext_d[vsize_q - 4'd1];
            val = sgn ? ext_d : ext_d - full;
            ev_d = '0; ev_d.comp = comp_q; ev_d.coef = val;
            ph_d = PhAcCode;
            if (ph_q == PhDcVal) begin
              ev_d.kind = KindDc; flg_d = 5'b00001; pos_d = 7'd1;
            end else begin
              ev_d.kind = KindAc; ev_d.run = vrun_q; flg_d = 5'b00001;
              pos_n = pos_q + 7'(vrun_q) + 7'd1;
              pos_d = pos_n;
              qual = sgn && (ext_d > 16'd1) && (vsize_q >= least_q) && !mdone;
              if (qual) begin
                if (skip_q != 8'd0) begin
                  skip_d = skip_q - 8'd1;
                end else begin
                  skip_d = skip_cnt_q;
                  hcnt_n = hcnt_q + 20'd1;
                  hcnt_d = hcnt_n;
                  if (hcnt_q < 20'd16) begin
                    hl_d = {hl_q[14:0], ext_d[0]};
                    ev_d.mlen = hl_d;
                    if (hcnt_n == 20'd16) begin
                      flg_d[1] = 1'b1;
                      flg_d[3] = (hl_d == 16'd0);
                    end
                  end else begin
                    acc_d = {acc_q[6:0], ext_d[0]};
                    ev_d.mlen = hl_q;
                    if (hcnt_n[2:0] == 3'd0) begin
                      flg_d[2] = 1'b1; ev_d.mbyte = acc_d; acc_d = '0;
                      hcnt_n = hcnt_n - 20'd16;
                      flg_d[3] = (hcnt_n[19:3] == {1'b0, hl_q});
                    end
                  end
                end
              end
              if (pos_n >= 7'd64) begin
                flg_d[4] = 1'b1; pos_d = '0; ph_d = PhDcCode;
                comp_d = (cnext >= {1'b0, (cc_q == 2'd0) ? 2'd1 : cc_q}) ? 2'd0 : cnext[1:0];
              end
            end
            more_d = 1'b1; state_d = StEmit;
          end else begin
            adv = 1'b1;
          end
        end else begin
          // code bit: shift in and read the count for the new length
          pc_d = {pc_q[14:0], bitv};
          plen_d = plen_n;
          state_d = StCnt;
        end
      end

      StCnt: begin
        if (match) begin
          state_d = StSym;
        end else begin
          base_d = (base_q + BaseW'(cnt_rdata)) << 1;
          off_d = off_q + OffW'(cnt_rdata);
          if (32'(plen_q) >= MaxCodeLength) begin
            pc_d = '0; plen_d = '0; base_d = '0; off_d = '0;
          end
          adv = 1'b1;
        end
      end

      StSym: begin
        pc_d = '0; plen_d = '0; base_d = '0; off_d = '0;
        ev_d = '0; ev_d.comp = comp_q; flg_d = '0;
        if (ph_q == PhDcCode) begin
          sz = (sym_rdata > 8'd15) ? 4'd15 : sym_rdata[3:0];
          if (sz == 4'd0) begin
            ev_d.kind = KindDc; flg_d = 5'b00001; pos_d = 7'd1; ph_d = PhAcCode;
          end else begin
            vsize_d = sz; vrun_d = '0; ext_d = '0; ph_d = PhDcVal;
          end
        end else begin
          sz = sym_rdata[3:0];
          if (sz == 4'd0) begin
            pos_n = pos_q + 7'd16;
            if (sym_rdata[7:4] == 4'd0) begin
              flg_d[4] = 1'b1;
            end else if (sym_rdata[7:4] == 4'd15) begin
              ev_d.kind = KindZrl; flg_d[0] = 1'b1; pos_d = pos_n;
              flg_d[4] = (pos_n >= 7'd64);
            end
            if (flg_d[4]) begin
              pos_d = '0; ph_d = PhDcCode;
              comp_d = (cnext >= {1'b0, (cc_q == 2'd0) ? 2'd1 : cc_q}) ? 2'd0 : cnext[1:0];
            end
          end else begin
            vsize_d = sz; vrun_d = sym_rdata[7:4]; ext_d = '0; ph_d = PhAcVal;
          end
        end
        if (flg_d != 5'd0) begin
          more_d = 1'b1; state_d = StEmit;
        end else begin
          adv = 1'b1;
        end
      end

      StEmit: begin
        // drain event results in order through the hold stage
        if (flg_q == 5'd0) begin
          if (more_q) begin
            adv = 1'b1;
          end else begin
            state_d = StFlush;
          end
        end else if (!pend_v_q || out_free) begin
          r = '0; r.comp = ev_q.comp;
          if (flg_q[0]) begin
            r.kind = ev_q.kind; r.run = ev_q.run; r.coef = ev_q.coef; flg_d[0] = 1'b0;
          end else if (flg_q[1]) begin
            r.kind = KindMsgLen; r.mlen = ev_q.mlen; flg_d[1] = 1'b0;
          end else if (flg_q[2]) begin
            r.kind = KindMsgByte; r.mbyte = ev_q.mbyte; r.mlen = ev_q.mlen;
            flg_d[2] = 1'b0;
          end else if (flg_q[3]) begin
            r.kind = KindMsgDone; r.mlen = ev_q.mlen; flg_d[3] = 1'b0;
          end else begin
            r.kind = KindEob; flg_d[4] = 1'b0;
          end
          if (pend_v_q) begin
            out_d = pend_q; out_last_d = 1'b0; out_v_d = 1'b1;
          end
          pend_d = r; pend_v_d = 1'b1;
        end
      end

      StFlush: begin
        // release the held result as the final one of this item
        if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_d = pend_q; out_last_d = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0; state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase

    if (adv) begin
      if (bidx_q == 3'd0) begin
        state_d = StFlush;
      end else begin
        bidx_d = bidx_q - 3'd1; state_d = StBit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 2'd3; c1_q <= 2'd0; c2_q <= 2'd3; c3_q <= 2'd3;
      skip_cnt_q <= '0; least_q <= 4'd2;
      state_q <= StIdle; bidx_q <= '0; mark_q <= 1'b0; stop_q <= 1'b0;
      more_q <= 1'b0; pc_q <= '0; ext_q <= '0; plen_q <= '0; ph_q <= PhDcCode;
      comp_q <= '0; pos_q <= '0; skip_q <= '0; acc_q <= '0; hcnt_q <= '0;
      hl_q <= '0; vsize_q <= '0; vrun_q <= '0; base_q <= '0; off_q <= '0;
      flg_q <= '0; pend_v_q <= 1'b0; out_v_q <= 1'b0; out_last_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegCompCount: cc_q <= cfg_data_i[1:0];
          RegComp1Tab:  c1_q <= cfg_data_i[1:0];
          RegComp2Tab:  c2_q <= cfg_data_i[1:0];
          RegComp3Tab:  c3_q <= cfg_data_i[1:0];
          RegSkipCount: skip_cnt_q <= cfg_data_i;
          RegLeastBits: least_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      state_q <= state_d; bidx_q <= bidx_d; mark_q <= mark_d; stop_q <= stop_d;
      more_q <= more_d; pc_q <= pc_d; ext_q <= ext_d; plen_q <= plen_d; ph_q <= ph_d;
      comp_q <= comp_d; pos_q <= pos_d; skip_q <= skip_d; acc_q <= acc_d;
      hcnt_q <= hcnt_d; hl_q <= hl_d; vsize_q <= vsize_d; vrun_q <= vrun_d;
      base_q <= base_d; off_q <= off_d; flg_q <= flg_d; pend_v_q <= pend_v_d;
      out_v_q <= out_v_d; out_last_q <= out_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; ev_q <= ev_d; pend_q <= pend_d; out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_q.mlen, out_q.mbyte, out_q.coef, out_q.run, out_q.comp};

  // no item is taken while a result of the previous one is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !pend_v_q)
    else $error("input taken with a held result");
  // a held result waits while the output register cannot take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && !out_free && state_q == StEmit) |=> pend_v_q)
    else $error("held result lost");
  // block position never rests at or beyond a full block between items
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == StIdle |-> pos_q < 7'd64)
    else $error("block position overflow");
  // code length stays within the longest code
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(plen_q) <= MaxCodeLength)
    else $error("partial code too long");
endmodule

FILE: rtl/jhsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jhsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
